// File: src/scc_pkg.sv
`timescale 1ns / 1ps

package scc_pkg;

    // Field widths of one transaction
    localparam int COORD_BITS    = 16;
    localparam int RAD_BITS      = COORD_BITS - 1;
    localparam int IN_FIELD_BITS = 8 * COORD_BITS + 2 * RAD_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 8;

    // Bit offsets of the input fields inside tdata
    localparam int OFF_A_X      = 0;
    localparam int OFF_A_Y      = OFF_A_X + COORD_BITS;
    localparam int OFF_A_PREV_X = OFF_A_Y + COORD_BITS;
    localparam int OFF_A_PREV_Y = OFF_A_PREV_X + COORD_BITS;
    localparam int OFF_A_RAD    = OFF_A_PREV_Y + COORD_BITS;
    localparam int OFF_B_X      = OFF_A_RAD + RAD_BITS;
    localparam int OFF_B_Y      = OFF_B_X + COORD_BITS;
    localparam int OFF_B_PREV_X = OFF_B_Y + COORD_BITS;
    localparam int OFF_B_PREV_Y = OFF_B_PREV_X + COORD_BITS;
    localparam int OFF_B_RAD    = OFF_B_PREV_Y + COORD_BITS;

    // Internal arithmetic widths
    localparam int DIFF_BITS = COORD_BITS + 1;     // centre difference
    localparam int VEL_BITS  = COORD_BITS + 2;     // relative motion
    localparam int RSUM_BITS = COORD_BITS;         // sum of radii
    localparam int SUM_BITS  = 2 * VEL_BITS;       // c, aa, bb (signed)
    localparam int MAG_BITS  = SUM_BITS - 1;       // magnitudes fed to the wide products
    localparam int HALF_LO   = (MAG_BITS + 1) / 2; // low slice of a split operand
    localparam int HALF_HI   = MAG_BITS - HALF_LO; // high slice of a split operand
    localparam int FULL_BITS = 2 * MAG_BITS;       // full wide product

    // Quadratic terms handed from the front end to the discriminant test
    typedef struct packed {
        logic signed [SUM_BITS-1:0] c;
        logic signed [SUM_BITS-1:0] aa;
        logic signed [SUM_BITS-1:0] bb;
        logic                       overlap;
        logic                       quiet;
    } scc_terms_t;

endpackage

// File: src/scc_terms.sv
`timescale 1ns / 1ps

module scc_terms
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [scc_pkg::COORD_BITS-1:0] a_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] a_y,
    input  logic signed [scc_pkg::COORD_BITS-1:0] a_prev_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] a_prev_y,
    input  logic        [scc_pkg::RAD_BITS-1:0]   a_rad,
    input  logic signed [scc_pkg::COORD_BITS-1:0] b_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] b_y,
    input  logic signed [scc_pkg::COORD_BITS-1:0] b_prev_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] b_prev_y,
    input  logic        [scc_pkg::RAD_BITS-1:0]   b_rad,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output scc_pkg::scc_terms_t                  out_terms
);

    localparam int DW = scc_pkg::DIFF_BITS;
    localparam int VW = scc_pkg::VEL_BITS;
    localparam int RW = scc_pkg::RSUM_BITS;
    localparam int SW = scc_pkg::SUM_BITS;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic signed [DW-1:0] dx_next, dy_next, dx_reg, dy_reg;
    logic signed [VW-1:0] vx_next, vy_next, vx_reg, vy_reg;
    logic        [RW-1:0] rs_next, rs_reg;

    logic signed [2*DW-1:0]    dxx_next, dyy_next, dxx_reg, dyy_reg;
    logic signed [2*VW-1:0]    vxx_next, vyy_next, vxx_reg, vyy_reg;
    logic signed [VW+DW-1:0]   vxd_next, vyd_next, vxd_reg, vyd_reg;
    logic        [2*RW-1:0]    rr_next, rr_reg;

    logic signed [SW-1:0] c_next, aa_next, bb_next;
    scc_pkg::scc_terms_t  terms_next, terms_reg;

    // Advance a stage when it is empty or the one after it moves
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 1: centre difference, relative motion, radius sum
    always_comb
    begin
        dx_next = DW'(b_x) - DW'(a_x);
        dy_next = DW'(b_y) - DW'(a_y);
        vx_next = VW'(b_x) - VW'(b_prev_x) - VW'(a_x) + VW'(a_prev_x);
        vy_next = VW'(b_y) - VW'(b_prev_y) - VW'(a_y) + VW'(a_prev_y);
        rs_next = RW'(a_rad) + RW'(b_rad);
    end

    // Stage 2: the seven narrow products
    always_comb
    begin
        dxx_next = dx_reg * dx_reg;
        dyy_next = dy_reg * dy_reg;
        vxx_next = vx_reg * vx_reg;
        vyy_next = vy_reg * vy_reg;
        vxd_next = vx_reg * dx_reg;
        vyd_next = vy_reg * dy_reg;
        rr_next  = rs_reg * rs_reg;
    end

    // Stage 3: sum into c, aa and bb, flag overlap and the no-approach case
    always_comb
    begin
        c_next  = SW'(dxx_reg) + SW'(dyy_reg) - SW'(rr_reg);
        aa_next = SW'(vxx_reg) + SW'(vyy_reg);
        bb_next = SW'(vxd_reg) + SW'(vyd_reg);
        terms_next.c       = c_next;
        terms_next.aa      = aa_next;
        terms_next.bb      = bb_next;
        terms_next.overlap = c_next[SW-1];
        terms_next.quiet   = (aa_next == '0) || !bb_next[SW-1];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            rs_reg <= rs_next;
        end
        if (en2)
        begin
            dxx_reg <= dxx_next;
            dyy_reg <= dyy_next;
            vxx_reg <= vxx_next;
            vyy_reg <= vyy_next;
            vxd_reg <= vxd_next;
            vyd_reg <= vyd_next;
            rr_reg  <= rr_next;
        end
        if (en3)
        begin
            terms_reg <= terms_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_terms = terms_reg;

endmodule

// File: src/scc_disc.sv
`timescale 1ns / 1ps

module scc_disc
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  scc_pkg::scc_terms_t in_terms,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                hit,
    output logic                overlap_now
);

    localparam int SW = scc_pkg::SUM_BITS;
    localparam int MW = scc_pkg::MAG_BITS;
    localparam int HL = scc_pkg::HALF_LO;
    localparam int HH = scc_pkg::HALF_HI;
    localparam int FW = scc_pkg::FULL_BITS;

    logic v4_reg, v5_reg, v6_reg, v7_reg;
    logic en4, en5, en6, en7;

    // Stage 4 values
    logic signed [SW-1:0] nb_full, e_full;
    logic [MW-1:0] nb_next, aa_next, c_next, e_next;
    logic [MW-1:0] nb_reg, aa_reg, c_reg, e_reg;
    logic e_le0_next, e_le0_reg;
    logic ovl4_reg, quiet4_reg;

    // Stage 5 partial products
    logic [MW+HL-1:0] nn_lo_next, ac_lo_next, ee_lo_next;
    logic [MW+HH-1:0] nn_hi_next, ac_hi_next, ee_hi_next;
    logic [MW+HL-1:0] nn_lo_reg, ac_lo_reg, ee_lo_reg;
    logic [MW+HH-1:0] nn_hi_reg, ac_hi_reg, ee_hi_reg;
    logic ovl5_reg, quiet5_reg, e_le05_reg;

    // Stage 6 full products
    logic [FW-1:0] sq_next, ad_next, esq_next;
    logic [FW-1:0] sq_reg, ad_reg, esq_reg;
    logic ovl6_reg, quiet6_reg, e_le06_reg;

    // Stage 7 result
    logic d_ok, e_ok, hit_next;
    logic hit_reg, ovl7_reg;

    assign en7      = !v7_reg || out_ready;
    assign en6      = !v6_reg || en7;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign in_ready = en4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (en4)
            begin
                v4_reg <= in_valid;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (en6)
            begin
                v6_reg <= v5_reg;
            end
            if (en7)
            begin
                v7_reg <= v6_reg;
            end
        end
    end

    // Stage 4: negate bb, form e = -bb - aa, reduce to magnitudes.
    // Where a magnitude is out of range the flags already settle the result.
    always_comb
    begin
        nb_full    = -in_terms.bb;
        e_full     = -in_terms.bb - in_terms.aa;
        nb_next    = nb_full[MW-1:0];
        aa_next    = in_terms.aa[MW-1:0];
        c_next     = in_terms.c[MW-1:0];
        e_next     = e_full[MW-1:0];
        e_le0_next = e_full[SW-1] || (e_full == '0);
    end

    // Stage 5: split each wide product on the second operand
    always_comb
    begin
        nn_lo_next = nb_reg * nb_reg[HL-1:0];
        nn_hi_next = nb_reg * nb_reg[MW-1:HL];
        ac_lo_next = aa_reg * c_reg[HL-1:0];
        ac_hi_next = aa_reg * c_reg[MW-1:HL];
        ee_lo_next = e_reg * e_reg[HL-1:0];
        ee_hi_next = e_reg * e_reg[MW-1:HL];
    end

    // Stage 6: recombine the halves
    always_comb
    begin
        sq_next  = FW'(nn_lo_reg) + (FW'(nn_hi_reg) << HL);
        ad_next  = FW'(ac_lo_reg) + (FW'(ac_hi_reg) << HL);
        esq_next = FW'(ee_lo_reg) + (FW'(ee_hi_reg) << HL);
    end

    // Stage 7: discriminant sign and the contact-before-end-of-frame test
    always_comb
    begin
        d_ok     = sq_reg >= ad_reg;
        e_ok     = (FW+1)'(sq_reg) >= ((FW+1)'(ad_reg) + (FW+1)'(esq_reg));
        hit_next = ovl6_reg || (!quiet6_reg && d_ok && (e_le06_reg || e_ok));
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            nb_reg     <= nb_next;
            aa_reg     <= aa_next;
            c_reg      <= c_next;
            e_reg      <= e_next;
            e_le0_reg  <= e_le0_next;
            ovl4_reg   <= in_terms.overlap;
            quiet4_reg <= in_terms.quiet;
        end
        if (en5)
        begin
            nn_lo_reg  <= nn_lo_next;
            nn_hi_reg  <= nn_hi_next;
            ac_lo_reg  <= ac_lo_next;
            ac_hi_reg  <= ac_hi_next;
            ee_lo_reg  <= ee_lo_next;
            ee_hi_reg  <= ee_hi_next;
            ovl5_reg   <= ovl4_reg;
            quiet5_reg <= quiet4_reg;
            e_le05_reg <= e_le0_reg;
        end
        if (en6)
        begin
            sq_reg     <= sq_next;
            ad_reg     <= ad_next;
            esq_reg    <= esq_next;
            ovl6_reg   <= ovl5_reg;
            quiet6_reg <= quiet5_reg;
            e_le06_reg <= e_le05_reg;
        end
        if (en7)
        begin
            hit_reg  <= hit_next;
            ovl7_reg <= ovl6_reg;
        end
    end

    assign out_valid   = v7_reg;
    assign hit         = hit_reg;
    assign overlap_now = ovl7_reg;

endmodule

// File: src/swept_circle_collision_test.sv
`timescale 1ns / 1ps

// Channel   Signals                      Direction  Contents
// s_*       s_tvalid s_tready s_tdata    in         one circle pair per transaction
// m_*       m_tvalid m_tready m_tdata    out        hit / overlap result per pair
//
// One pair is taken every cycle while the output is not stalled; each result
// passes through seven register stages after its transaction (three for the quadratic
// terms, four for the split wide products and the discriminant compare).
// Reset clears only the stage valid bits; data registers are not reset.
// A full stage holds while the stage after it is full and stalled; empty
// stages keep filling, so input is still taken while a result waits.

module swept_circle_collision_test
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // a_x, a_y, a_prev_x, a_prev_y, a_rad, b_x, b_y, b_prev_x, b_prev_y, b_rad, zero pad
    input  logic [scc_pkg::IN_DATA_BITS-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // hit, overlap_now, zero pad
    output logic [scc_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

    localparam int CB = scc_pkg::COORD_BITS;
    localparam int RB = scc_pkg::RAD_BITS;

    logic signed [CB-1:0] a_x, a_y, a_prev_x, a_prev_y;
    logic signed [CB-1:0] b_x, b_y, b_prev_x, b_prev_y;
    logic        [RB-1:0] a_rad, b_rad;

    logic                terms_valid, terms_ready;
    scc_pkg::scc_terms_t terms;
    logic                hit, overlap_now;

    // Unpack the transaction fields
    assign a_x      = s_tdata[scc_pkg::OFF_A_X      +: CB];
    assign a_y      = s_tdata[scc_pkg::OFF_A_Y      +: CB];
    assign a_prev_x = s_tdata[scc_pkg::OFF_A_PREV_X +: CB];
    assign a_prev_y = s_tdata[scc_pkg::OFF_A_PREV_Y +: CB];
    assign a_rad    = s_tdata[scc_pkg::OFF_A_RAD    +: RB];
    assign b_x      = s_tdata[scc_pkg::OFF_B_X      +: CB];
    assign b_y      = s_tdata[scc_pkg::OFF_B_Y      +: CB];
    assign b_prev_x = s_tdata[scc_pkg::OFF_B_PREV_X +: CB];
    assign b_prev_y = s_tdata[scc_pkg::OFF_B_PREV_Y +: CB];
    assign b_rad    = s_tdata[scc_pkg::OFF_B_RAD    +: RB];

    scc_terms u_terms
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_prev_x  (a_prev_x),
        .a_prev_y  (a_prev_y),
        .a_rad     (a_rad),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_prev_x  (b_prev_x),
        .b_prev_y  (b_prev_y),
        .b_rad     (b_rad),
        .out_valid (terms_valid),
        .out_ready (terms_ready),
        .out_terms (terms)
    );

    scc_disc u_disc
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (terms_valid),
        .in_ready    (terms_ready),
        .in_terms    (terms),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .hit         (hit),
        .overlap_now (overlap_now)
    );

    // Pack the result, zero pad to a whole byte
    assign m_tdata = {{(scc_pkg::OUT_DATA_BITS - 2){1'b0}}, overlap_now, hit};

endmodule
